/* rtl/swrl_pkg.sv */
// Package: sizes, decision codes and sequencer states of the sliding-window rate limiter.
package swrl_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int MAX_LIMIT     = 8;
    localparam int ENTRY_W       = $clog2(TABLE_ENTRIES);
    localparam int SLOT_W        = $clog2(MAX_LIMIT);
    localparam int STAMP_AW      = ENTRY_W + SLOT_W;
    localparam int CNT_W         = 4;
    localparam int KEY_W         = 32;
    localparam int TIME_W        = 32;
    localparam int LIMIT_W       = 4;
    localparam int WINDOW_W      = 16;
    localparam int CFG_DATA_W    = 16;

    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(5);
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(10);

    typedef enum logic [0:0] {
        CFG_LIMIT  = 1'b0,
        CFG_WINDOW = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DEC_ALLOWED = 2'd0,
        DEC_LIMITED = 2'd1,
        DEC_FULL    = 2'd2
    } t_decision;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_FREE,
        S_FCNT,
        S_SRD,
        S_SCHK,
        S_DEC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] cnt;
    } t_entry;

endpackage

/* rtl/sliding_window_rate_limiter.sv */
// Sliding-window log rate limiter: key search, stamp prune and allocate under one sequencer.
// A key hit prunes the entry's stale stamps before the decision is made.
// Miss: after the key search, entries are taken in turn; an invalid or all-stale one is allocated.
// One word at a time: o_ready is high only when idle, so no new word is taken before the last result.
// Synchronous active-low reset clears the valid bits, the sequencer and the config registers
// (limit 5, window 10); key, count and stamp memories are not cleared.
module sliding_window_rate_limiter
    import swrl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [KEY_W-1:0]      i_client_ip,
    input  logic [TIME_W-1:0]     i_now_time,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_decision,
    output logic [CNT_W-1:0]      o_window_count,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [ENTRY_W-1:0] LAST_ENTRY = ENTRY_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0]   MAX_CNT    = CNT_W'(MAX_LIMIT);

    t_state                 r_state, n_state;
    logic [ENTRY_W-1:0]     r_idx, n_idx;
    logic [ENTRY_W-1:0]     r_pidx, n_pidx;
    logic                   r_kv, n_kv;
    logic [ENTRY_W-1:0]     r_e, n_e;
    logic [CNT_W-1:0]       r_n, n_n;
    logic [CNT_W-1:0]       r_i, n_i;
    logic [CNT_W-1:0]       r_k, n_k;
    logic                   r_prune, n_prune;
    t_decision              r_dec, n_dec;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [KEY_W-1:0]       r_ip;
    logic [TIME_W-1:0]      r_now;
    logic [LIMIT_W-1:0]     r_limit;
    logic [WINDOW_W-1:0]    r_window;
    logic [TABLE_ENTRIES-1:0] r_vbits;

    t_entry                 r_ent_mem [TABLE_ENTRIES];
    t_entry                 r_ent_q;
    logic [TIME_W-1:0]      r_stamp_mem [TABLE_ENTRIES * MAX_LIMIT];
    logic [TIME_W-1:0]      r_stamp_q;

    logic [ENTRY_W-1:0]     ent_raddr;
    logic                   ent_we;
    t_entry                 ent_wdata;
    logic [STAMP_AW-1:0]    stp_raddr;
    logic                   stp_we;
    logic [STAMP_AW-1:0]    stp_waddr;
    logic [TIME_W-1:0]      stp_wdata;
    logic                   set_valid;

    logic [CNT_W-1:0]       q_sat;
    logic [LIMIT_W-1:0]     lim;
    logic [TIME_W-1:0]      age;
    logic                   live;

    assign q_sat = (r_ent_q.cnt > MAX_CNT) ? MAX_CNT : r_ent_q.cnt;
    assign lim   = (r_limit > LIMIT_W'(MAX_LIMIT)) ? LIMIT_W'(MAX_LIMIT) : r_limit;
    assign age   = r_now - r_stamp_q;
    assign live  = (age <= {{(TIME_W-WINDOW_W){1'b0}}, r_window});

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_decision     = r_dec;
    assign o_window_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIMIT_RESET;
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LIMIT:  r_limit  <= i_cfg_data[LIMIT_W-1:0];
                CFG_WINDOW: r_window <= i_cfg_data[WINDOW_W-1:0];
                default:    r_limit  <= r_limit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ent_mem[r_e] <= ent_wdata;
        end
        r_ent_q <= r_ent_mem[ent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stp_we) begin
            r_stamp_mem[stp_waddr] <= stp_wdata;
        end
        r_stamp_q <= r_stamp_mem[stp_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kv    <= 1'b0;
            r_vbits <= '0;
            r_dec   <= DEC_ALLOWED;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_kv    <= n_kv;
            r_dec   <= n_dec;
            r_cnt   <= n_cnt;
            if (set_valid) begin
                r_vbits[r_e] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_pidx  <= n_pidx;
        r_e     <= n_e;
        r_n     <= n_n;
        r_i     <= n_i;
        r_k     <= n_k;
        r_prune <= n_prune;
        if (i_valid && o_ready) begin
            r_ip  <= i_client_ip;
            r_now <= i_now_time;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_pidx    = r_pidx;
        n_kv      = 1'b0;
        n_e       = r_e;
        n_n       = r_n;
        n_i       = r_i;
        n_k       = r_k;
        n_prune   = r_prune;
        n_dec     = r_dec;
        n_cnt     = r_cnt;
        ent_raddr = r_idx;
        ent_we    = 1'b0;
        ent_wdata = '{key: r_ip, cnt: r_k};
        stp_raddr = {r_e, r_i[SLOT_W-1:0]};
        stp_we    = 1'b0;
        stp_waddr = {r_e, r_k[SLOT_W-1:0]};
        stp_wdata = r_stamp_q;
        set_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_idx   = '0;
                    n_state = S_KEY;
                end
            end
            S_KEY: begin
                // pipelined scan: r_ent_q holds the entry at r_pidx
                n_idx  = r_idx + ENTRY_W'(1);
                n_pidx = r_idx;
                n_kv   = 1'b1;
                if (r_kv) begin
                    if (r_vbits[r_pidx] && (r_ent_q.key == r_ip)) begin
                        n_kv    = 1'b0;
                        n_e     = r_pidx;
                        n_n     = q_sat;
                        n_i     = '0;
                        n_k     = '0;
                        n_prune = 1'b1;
                        n_state = (q_sat == '0) ? S_DEC : S_SRD;
                    end else if (r_pidx == LAST_ENTRY) begin
                        n_kv    = 1'b0;
                        n_e     = '0;
                        n_state = S_FREE;
                    end
                end
            end
            S_FREE: begin
                ent_raddr = r_e;
                if (!r_vbits[r_e]) begin
                    set_valid = 1'b1;
                    n_k       = '0;
                    n_state   = S_DEC;
                end else begin
                    n_state = S_FCNT;
                end
            end
            S_FCNT: begin
                n_n     = q_sat;
                n_i     = '0;
                n_k     = '0;
                n_prune = 1'b0;
                if (q_sat == '0) begin
                    set_valid = 1'b1;
                    n_state   = S_DEC;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                n_state = S_SCHK;
            end
            S_SCHK: begin
                n_i = r_i + CNT_W'(1);
                if (r_prune) begin
                    if (live) begin
                        stp_we = 1'b1;
                        n_k    = r_k + CNT_W'(1);
                    end
                    n_state = (n_i == r_n) ? S_DEC : S_SRD;
                end else if (live) begin
                    // entry still in use, try the next one
                    if (r_e == LAST_ENTRY) begin
                        n_dec   = DEC_FULL;
                        n_cnt   = '0;
                        n_state = S_OUT;
                    end else begin
                        n_e     = r_e + ENTRY_W'(1);
                        n_state = S_FREE;
                    end
                end else if (n_i == r_n) begin
                    set_valid = 1'b1;
                    n_k       = '0;
                    n_state   = S_DEC;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_DEC: begin
                ent_we = 1'b1;
                if (r_k >= CNT_W'(lim)) begin
                    n_dec = DEC_LIMITED;
                    n_cnt = r_k;
                end else begin
                    stp_we        = 1'b1;
                    stp_wdata     = r_now;
                    n_cnt         = r_k + CNT_W'(1);
                    ent_wdata.cnt = r_k + CNT_W'(1);
                    n_dec         = DEC_ALLOWED;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/swrl_checker.sv */
// Port-level checker for the rate limiter, bound to the sliding_window_rate_limiter module.
module swrl_checker
    import swrl_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input logic [1:0]       o_decision,
    input logic [CNT_W-1:0] o_window_count
);

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_decision == DEC_FULL)) |-> (o_window_count == '0))
        else $error("table full word with nonzero count");

    a_allow_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_decision == DEC_ALLOWED)) |->
        ((o_window_count != '0) && (o_window_count <= CNT_W'(MAX_LIMIT))))
        else $error("allowed word with bad count");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("ready while a result is pending");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_valid)
        else $error("result in the cycle after accept");

    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> o_ready)
        else $error("not idle after result taken");

endmodule

bind sliding_window_rate_limiter swrl_checker u_swrl_checker (.*);

/* tb/tb_top.sv */
// Testbench for the sliding-window rate limiter: directed table and random phases against a predictor.
module tb_top;
    import swrl_pkg::*;

    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 1300;
    localparam int N_PHASES    = 12;
    localparam int PHASE_WORDS = 105;
    localparam int N_ROWS      = 29;
    localparam int MAX_REPORTS = 100;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        t_cfg_idx           idx;
        logic [KEY_W-1:0]   ip;
        logic [TIME_W-1:0]  val;
        logic               pinned;
        t_decision          dec;
        logic [CNT_W-1:0]   cnt;
    } t_stim_row;

    typedef struct packed {
        t_decision        dec;
        logic [CNT_W-1:0] cnt;
    } t_verdict;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_valid        = 1'b0;
    logic                  o_ready;
    logic [KEY_W-1:0]      i_client_ip    = '0;
    logic [TIME_W-1:0]     i_now_time     = '0;
    logic                  o_valid;
    logic                  i_ready        = 1'b0;
    logic [1:0]            o_decision;
    logic [CNT_W-1:0]      o_window_count;
    logic                  i_cfg_we       = 1'b0;
    logic                  i_cfg_idx      = 1'b0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    sliding_window_rate_limiter u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_client_ip    (i_client_ip),
        .i_now_time     (i_now_time),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_decision     (o_decision),
        .o_window_count (o_window_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // shadow of the client table and registers
    bit                 tbl_valid [TABLE_ENTRIES];
    logic [KEY_W-1:0]   tbl_key   [TABLE_ENTRIES];
    int                 tbl_cnt   [TABLE_ENTRIES];
    logic [TIME_W-1:0]  tbl_stamp [TABLE_ENTRIES][MAX_LIMIT];
    logic [LIMIT_W-1:0]  limit_shadow  = LIMIT_RESET;
    logic [WINDOW_W-1:0] window_shadow = WINDOW_RESET;

    t_verdict verdict_q [$];
    int       mismatches   = 0;
    int       cycles       = 0;
    bit       calm         = 1'b0;
    bit       hold_off_req = 1'b0;
    bit       pin_on       = 1'b0;
    t_decision        pin_dec = DEC_ALLOWED;
    logic [CNT_W-1:0] pin_cnt = '0;

    t_stim_row script [N_ROWS] = '{
        '{ROW_REQ, CFG_LIMIT,  32'h0000_0000, 32'd0,         1'b1, DEC_ALLOWED, 4'd1},
        '{ROW_REQ, CFG_LIMIT,  32'h0000_0000, 32'd1,         1'b0, DEC_ALLOWED, 4'd0},
        '{ROW_REQ, CFG_LIMIT,  32'h0000_0000, 32'd2,         1'b0, DEC_ALLOWED, 4'd0},
        '{ROW_REQ, CFG_LIMIT,  32'h0000_0000, 32'd3,         1'b0, DEC_ALLOWED, 4'd0},
        '{ROW_REQ, CFG_LIMIT,  32'h0000_0000, 32'd4,         1'b1, DEC_ALLOWED, 4'd5},
        '{ROW_REQ, CFG_LIMIT,  32'h0000_0000, 32'd5,         1'b1, DEC_LIMITED, 4'd5},
        '{ROW_REQ, CFG_LIMIT,  32'h0000_0000, 32'd11,        1'b1, DEC_ALLOWED, 4'd5},
        '{ROW_REQ, CFG_LIMIT,  32'hFFFF_FFFF, 32'd11,        1'b1, DEC_ALLOWED, 4'd1},
        '{ROW_CFG, CFG_LIMIT,  32'h0000_0000, 32'h0000_0000, 1'b0, DEC_ALLOWED, 4'd0},
        '{ROW_REQ, CFG_LIMIT,  32'h0000_0000, 32'd12,        1'b0, DEC_ALLOWED, 4'd0},
        '{ROW_REQ, CFG_LIMIT,  32'h1234_5678, 32'd12,        1'b1, DEC_LIMITED, 4'd0},
        '{ROW_CFG, CFG_LIMIT,  32'h0000_0000, 32'h0000_FFFF, 1'b0, DEC_ALLOWED, 4'd0},
        '{ROW_REQ, CFG_LIMIT,  32'hA5A5_A5A5, 32'd20,        1'b0, DEC_ALLOWED, 4'd0},
        '{ROW_REQ, CFG_LIMIT,  32'hA5A5_A5A5, 32'd20,        1'b0, DEC_ALLOWED, 4'd0},
        '{ROW_REQ, CFG_LIMIT,  32'hA5A5_A5A5, 32'd20,        1'b0, DEC_ALLOWED, 4'd0},
        '{ROW_REQ, CFG_LIMIT,  32'hA5A5_A5A5, 32'd20,        1'b0, DEC_ALLOWED, 4'd0},
        '{ROW_REQ, CFG_LIMIT,  32'hA5A5_A5A5, 32'd20,        1'b0, DEC_ALLOWED, 4'd0},
        '{ROW_REQ, CFG_LIMIT,  32'hA5A5_A5A5, 32'd20,        1'b0, DEC_ALLOWED, 4'd0},
        '{ROW_REQ, CFG_LIMIT,  32'hA5A5_A5A5, 32'd20,        1'b0, DEC_ALLOWED, 4'd0},
        '{ROW_REQ, CFG_LIMIT,  32'hA5A5_A5A5, 32'd20,        1'b0, DEC_ALLOWED, 4'd0},
        '{ROW_REQ, CFG_LIMIT,  32'hA5A5_A5A5, 32'd20,        1'b1, DEC_LIMITED, 4'd8},
        '{ROW_CFG, CFG_WINDOW, 32'h0000_0000, 32'h0000_0000, 1'b0, DEC_ALLOWED, 4'd0},
        '{ROW_REQ, CFG_LIMIT,  32'hA5A5_A5A5, 32'd20,        1'b1, DEC_LIMITED, 4'd8},
        '{ROW_REQ, CFG_LIMIT,  32'hA5A5_A5A5, 32'd21,        1'b1, DEC_ALLOWED, 4'd1},
        '{ROW_CFG, CFG_WINDOW, 32'h0000_0000, 32'h0000_FFFF, 1'b0, DEC_ALLOWED, 4'd0},
        '{ROW_CFG, CFG_LIMIT,  32'h0000_0000, 32'h0000_0008, 1'b0, DEC_ALLOWED, 4'd0},
        '{ROW_REQ, CFG_LIMIT,  32'h0000_0000, 32'd5,         1'b0, DEC_ALLOWED, 4'd0},
        '{ROW_REQ, CFG_LIMIT,  32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b0, DEC_ALLOWED, 4'd0},
        '{ROW_REQ, CFG_LIMIT,  32'h5A5A_5A5A, 32'h0000_0003, 1'b0, DEC_ALLOWED, 4'd0}
    };

    function automatic bit stale(input logic [TIME_W-1:0] stamp, input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] age;
        age = now - stamp;
        return age > {16'd0, window_shadow};
    endfunction

    function automatic void judge_request(input logic [KEY_W-1:0] ip,
                                          input logic [TIME_W-1:0] now,
                                          output t_decision dec,
                                          output logic [CNT_W-1:0] cnt);
        int lim;
        int hit;
        int e;
        int k;
        int live;
        bit found;
        lim = (limit_shadow > MAX_LIMIT) ? MAX_LIMIT : int'(limit_shadow);
        hit = -1;
        for (e = 0; e < TABLE_ENTRIES; e++) begin
            if (hit < 0 && tbl_valid[e] && tbl_key[e] == ip) begin
                hit = e;
            end
        end
        found = (hit >= 0);
        if (!found) begin
            for (e = 0; e < TABLE_ENTRIES; e++) begin
                if (hit < 0) begin
                    live = 0;
                    if (tbl_valid[e]) begin
                        for (k = 0; k < tbl_cnt[e]; k++) begin
                            if (!stale(tbl_stamp[e][k], now)) begin
                                live++;
                            end
                        end
                    end
                    if (!tbl_valid[e] || live == 0) begin
                        hit = e;
                    end
                end
            end
            if (hit < 0) begin
                dec = DEC_FULL;
                cnt = '0;
                return;
            end
            tbl_valid[hit] = 1'b1;
            tbl_key[hit]   = ip;
            tbl_cnt[hit]   = 0;
        end else begin
            k = 0;
            for (e = 0; e < tbl_cnt[hit]; e++) begin
                if (!stale(tbl_stamp[hit][e], now)) begin
                    tbl_stamp[hit][k] = tbl_stamp[hit][e];
                    k++;
                end
            end
            tbl_cnt[hit] = k;
        end
        if (tbl_cnt[hit] >= lim) begin
            dec = DEC_LIMITED;
        end else begin
            tbl_stamp[hit][tbl_cnt[hit]] = now;
            tbl_cnt[hit]++;
            dec = DEC_ALLOWED;
        end
        cnt = CNT_W'(tbl_cnt[hit]);
    endfunction

    always @(posedge i_clk) begin : accept_mon
        t_decision        d;
        logic [CNT_W-1:0] c;
        t_verdict         v;
        if (i_rst_n && i_valid && o_ready) begin
            judge_request(i_client_ip, i_now_time, d, c);
            if (pin_on) begin
                v = '{pin_dec, pin_cnt};
            end else begin
                v = '{d, c};
            end
            verdict_q.insert(verdict_q.size(), v);
        end
    end

    always @(posedge i_clk) begin : result_mon
        t_verdict want;
        if (i_rst_n && o_valid && i_ready) begin
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $error("unexpected word: decision %0d window_count %0d",
                           o_decision, o_window_count);
                end
            end else begin
                want = verdict_q.pop_front();
                if (o_decision !== want.dec) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $error("decision: expected %0d, got %0d", want.dec, o_decision);
                    end
                end
                if (o_window_count !== want.cnt) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $error("window_count: expected %0d, got %0d", want.cnt, o_window_count);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin : sink
        int hold_left;
        int stall_left;
        int run_left;
        hold_left  = 0;
        stall_left = 0;
        run_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && hold_left == 0) begin
                hold_left    = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0) begin
                i_ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0 && !calm) begin
                i_ready = 1'b0;
                stall_left--;
            end else if (run_left > 0 || calm) begin
                i_ready = 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end
            end else if ($urandom_range(0, 1) == 0) begin
                i_ready    = 1'b0;
                stall_left = $urandom_range(1, 5) - 1;
            end else begin
                i_ready  = 1'b1;
                run_left = $urandom_range(1, 12) - 1;
            end
        end
    end

    task automatic send_word(input logic [KEY_W-1:0] ip, input logic [TIME_W-1:0] now,
                             input bit pinned, input t_decision pdec,
                             input logic [CNT_W-1:0] pcnt);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pin_on      = pinned;
        pin_dec     = pdec;
        pin_cnt     = pcnt;
        i_client_ip = ip;
        i_now_time  = now;
        i_valid     = 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        if (idx == CFG_LIMIT) begin
            limit_shadow = data[LIMIT_W-1:0];
        end else begin
            window_shadow = data[WINDOW_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin : stim
        logic [KEY_W-1:0]    pool [80];
        logic [KEY_W-1:0]    ip;
        logic [TIME_W-1:0]   t_sec;
        logic [TIME_W-1:0]   t_item;
        logic [LIMIT_W-1:0]  lim_val;
        logic [WINDOW_W-1:0] win_val;
        int                  span;
        int                  flavor;
        int                  r;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (r = 0; r < N_ROWS; r++) begin
            if (script[r].kind == ROW_CFG) begin
                drain();
                write_reg(script[r].idx, script[r].val[CFG_DATA_W-1:0]);
            end else begin
                send_word(script[r].ip, script[r].val, script[r].pinned,
                          script[r].dec, script[r].cnt);
            end
        end
        drain();

        t_sec = $urandom;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            calm   = (ph >= N_PHASES - 2);
            flavor = ph % 3;
            if (ph == 0) begin
                lim_val = 4'd1;
                win_val = 16'd1;
            end else if (ph == 1) begin
                lim_val = 4'd8;
                win_val = 16'hFFFF;
            end else begin
                case ($urandom_range(0, 5))
                    0:       lim_val = 4'd0;
                    1:       lim_val = LIMIT_W'($urandom_range(9, 15));
                    default: lim_val = LIMIT_W'($urandom_range(1, 8));
                endcase
                if (flavor == 1) begin
                    win_val = WINDOW_W'($urandom_range(200, 65535));
                end else begin
                    case ($urandom_range(0, 4))
                        0:       win_val = 16'd0;
                        1:       win_val = 16'd1;
                        2:       win_val = 16'hFFFF;
                        3:       win_val = WINDOW_W'($urandom_range(2, 40));
                        default: win_val = WINDOW_W'($urandom_range(0, 65535));
                    endcase
                end
            end
            write_reg(CFG_LIMIT, {12'($urandom_range(0, 4095)), lim_val});
            write_reg(CFG_WINDOW, win_val);

            // small client pool for repeat traffic, wide pool to fill the table
            span = (flavor == 1) ? 80 : 8;
            for (int i = 0; i < span; i++) begin
                pool[i] = $urandom;
            end
            t_sec += 70000 + $urandom_range(0, 1000);
            if (ph == 2) begin
                hold_off_req = 1'b1;
            end

            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    t_sec += $urandom_range(0, 2 * int'(window_shadow) + 2);
                end else begin
                    t_sec += $urandom_range(0, (flavor == 1) ? 1 : 3);
                end
                ip     = pool[$urandom_range(0, span - 1)];
                t_item = t_sec;
                if (flavor == 2 && $urandom_range(0, 1) == 0) begin
                    ip     = $urandom;
                    t_item = $urandom;
                end
                send_word(ip, t_item, 1'b0, DEC_ALLOWED, '0);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
